// ===== rtl/core/sau_pkg.sv =====
// Shared types and constants for the stack arithmetic unit.
`default_nettype none
package sau_pkg;

  localparam int WORD_W          = 32;
  localparam int FUNC_W          = 3;
  localparam int STATUS_W        = 2;
  localparam int DEPTH_W         = 7;
  localparam int STACK_DEPTH_DEF = 64;
  localparam int OPERANDS        = 2;

  localparam logic [FUNC_W-1:0] FN_PUSH = 3'd0;
  localparam logic [FUNC_W-1:0] FN_ADD  = 3'd1;
  localparam logic [FUNC_W-1:0] FN_SUB  = 3'd2;
  localparam logic [FUNC_W-1:0] FN_MUL  = 3'd3;
  localparam logic [FUNC_W-1:0] FN_DIV  = 3'd4;
  localparam logic [FUNC_W-1:0] FN_MOD  = 3'd5;

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_SHORT   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_DIVZERO = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd3;

  typedef logic [WORD_W-1:0] word_t;

  // request from the sequencer to the arithmetic unit
  typedef struct packed {
    logic              start;
    logic [FUNC_W-1:0] func;
  } alu_req_t;

endpackage
`default_nettype wire

// ===== rtl/core/sau_stack_mem.sv =====
// Word store for the stack entries below the top.
`default_nettype none
module sau_stack_mem
  import sau_pkg::*;
#(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF,
  parameter int AW          = $clog2(STACK_DEPTH)
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire word_t         wr_data,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output word_t              rd_data
);

  word_t mem_r [STACK_DEPTH];
  word_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

// ===== rtl/core/sau_alu.sv =====
// Shared arithmetic unit: one adder used for add/sub, shift-add multiply and restoring divide.
`default_nettype none
module sau_alu
  import sau_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire alu_req_t req,
  input  wire word_t    opa,
  input  wire word_t    opb,
  output logic          done,
  output word_t         result
);

  typedef enum logic [1:0] {A_IDLE, A_MUL, A_DIV, A_FIX} alu_state_t;

  localparam int CNT_W = $clog2(WORD_W);

  alu_state_t state_r, state_nxt;
  word_t      acc_r, acc_nxt;     // product accumulator / partial remainder
  word_t      sh_r, sh_nxt;       // multiplicand / dividend-quotient
  word_t      op_r, op_nxt;       // multiplier / divisor
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic       neg_q_r, neg_q_nxt;
  logic       neg_m_r, neg_m_nxt;
  logic       is_mod_r, is_mod_nxt;
  word_t      res_r, res_nxt;
  logic       done_r, done_nxt;

  logic [WORD_W:0]   add_x, add_y;
  logic              add_sub;
  logic [WORD_W+1:0] sum;
  word_t             abs_a, abs_b, fix_sel;
  logic              fix_neg;
  logic              last;

  assign abs_a   = opa[WORD_W-1] ? word_t'(-opa) : opa;
  assign abs_b   = opb[WORD_W-1] ? word_t'(-opb) : opb;
  assign fix_sel = is_mod_r ? acc_r : sh_r;
  assign fix_neg = is_mod_r ? neg_m_r : neg_q_r;
  assign last    = (cnt_r == CNT_W'(WORD_W - 1));

  // the one adder; bit WORD_W+1 is the carry out, set when x >= y on a subtract
  always_comb begin
    add_x   = '0;
    add_y   = '0;
    add_sub = 1'b0;
    unique case (state_r)
      A_IDLE: begin
        add_x   = {1'b0, opa};
        add_y   = {1'b0, opb};
        add_sub = (req.func == FN_SUB);
      end
      A_MUL: begin
        add_x = {1'b0, acc_r};
        add_y = {1'b0, sh_r};
      end
      A_DIV: begin
        add_x   = {acc_r, sh_r[WORD_W-1]};
        add_y   = {1'b0, op_r};
        add_sub = 1'b1;
      end
      A_FIX: begin
        add_y   = {1'b0, fix_sel};
        add_sub = 1'b1;
      end
      default: ;
    endcase
    sum = {1'b0, add_x} + {1'b0, (add_sub ? ~add_y : add_y)} + (WORD_W+2)'(add_sub);
  end

  always_comb begin
    state_nxt  = state_r;
    acc_nxt    = acc_r;
    sh_nxt     = sh_r;
    op_nxt     = op_r;
    cnt_nxt    = cnt_r;
    neg_q_nxt  = neg_q_r;
    neg_m_nxt  = neg_m_r;
    is_mod_nxt = is_mod_r;
    res_nxt    = res_r;
    done_nxt   = 1'b0;
    unique case (state_r)
      A_IDLE: begin
        if (req.start) begin
          cnt_nxt = '0;
          acc_nxt = '0;
          case (req.func)
            FN_MUL: begin
              sh_nxt    = opa;
              op_nxt    = opb;
              state_nxt = A_MUL;
            end
            FN_DIV, FN_MOD: begin
              sh_nxt     = abs_a;
              op_nxt     = abs_b;
              neg_q_nxt  = opa[WORD_W-1] ^ opb[WORD_W-1];
              neg_m_nxt  = opa[WORD_W-1];
              is_mod_nxt = (req.func == FN_MOD);
              state_nxt  = A_DIV;
            end
            default: begin
              res_nxt  = sum[WORD_W-1:0];
              done_nxt = 1'b1;
            end
          endcase
        end
      end
      A_MUL: begin
        if (op_r[0]) begin
          acc_nxt = sum[WORD_W-1:0];
        end
        sh_nxt  = {sh_r[WORD_W-2:0], 1'b0};
        op_nxt  = {1'b0, op_r[WORD_W-1:1]};
        cnt_nxt = cnt_r + CNT_W'(1);
        if (last) begin
          res_nxt   = op_r[0] ? sum[WORD_W-1:0] : acc_r;
          done_nxt  = 1'b1;
          state_nxt = A_IDLE;
        end
      end
      A_DIV: begin
        if (sum[WORD_W+1]) begin
          acc_nxt = sum[WORD_W-1:0];
          sh_nxt  = {sh_r[WORD_W-2:0], 1'b1};
        end else begin
          acc_nxt = {acc_r[WORD_W-2:0], sh_r[WORD_W-1]};
          sh_nxt  = {sh_r[WORD_W-2:0], 1'b0};
        end
        cnt_nxt = cnt_r + CNT_W'(1);
        if (last) begin
          state_nxt = A_FIX;
        end
      end
      A_FIX: begin
        // quotient takes the xor of the signs, remainder the dividend's
        res_nxt   = fix_neg ? sum[WORD_W-1:0] : fix_sel;
        done_nxt  = 1'b1;
        state_nxt = A_IDLE;
      end
      default: state_nxt = A_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= A_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
    acc_r    <= acc_nxt;
    sh_r     <= sh_nxt;
    op_r     <= op_nxt;
    cnt_r    <= cnt_nxt;
    neg_q_r  <= neg_q_nxt;
    neg_m_r  <= neg_m_nxt;
    is_mod_r <= is_mod_nxt;
    res_r    <= res_nxt;
  end

  assign done   = done_r;
  assign result = res_r;

endmodule
`default_nettype wire

// ===== rtl/core/stack_arithmetic_unit.sv =====
// Stack arithmetic unit: request sequencer, cached top of stack and entry count.
// Push, unused codes, short or full stack: strobe in the next cycle, 1 request a cycle.
// Division by zero: strobe after S_OPER; other ops wait in S_WAIT on the shared adder
// (one bit a cycle for mul and div/mod, plus a sign fix-up). busy is high until the strobe.
// rst_n (synchronous) empties the stack; entry contents are not cleared.
// The receiver cannot stall: out_valid flags each result on the out_ ports for one cycle.
`default_nettype none
module stack_arithmetic_unit
  import sau_pkg::*;
#(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic [FUNC_W-1:0]   in_func,
  input  wire logic signed [WORD_W-1:0] in_push_value,
  output logic                     out_valid,
  output logic [STATUS_W-1:0]      out_status,
  output logic signed [WORD_W-1:0] out_top_value,
  output logic [DEPTH_W-1:0]       out_depth
);

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);

  typedef enum logic [1:0] {S_IDLE, S_OPER, S_WAIT} seq_state_t;

  seq_state_t          state_r, state_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  word_t               top_r, top_nxt;
  logic [FUNC_W-1:0]   func_r, func_nxt;
  logic                ovalid_r, ovalid_nxt;
  logic [STATUS_W-1:0] ostatus_r, ostatus_nxt;
  word_t               otop_r, otop_nxt;
  logic [DEPTH_W-1:0]  odepth_r, odepth_nxt;

  logic          wr_en, rd_en;
  logic [CW-1:0] count_m1, count_m2;
  word_t         second;
  word_t         cur_top;
  alu_req_t      alu_req;
  logic          alu_done;
  word_t         alu_res;

  function automatic logic [DEPTH_W-1:0] to_depth(input logic [CW-1:0] c);
    logic [CW+DEPTH_W-1:0] e;
    e = {{DEPTH_W{1'b0}}, c};
    return e[DEPTH_W-1:0];
  endfunction

  assign count_m1 = count_r - CW'(1);
  assign count_m2 = count_r - CW'(OPERANDS);
  assign cur_top  = (count_r != '0) ? top_r : '0;

  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    top_nxt     = top_r;
    func_nxt    = func_r;
    ovalid_nxt  = 1'b0;
    ostatus_nxt = ostatus_r;
    otop_nxt    = otop_r;
    odepth_nxt  = odepth_r;
    wr_en       = 1'b0;
    rd_en       = 1'b0;
    alu_req     = '{start: 1'b0, func: func_r};
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          func_nxt = in_func;
          case (in_func)
            FN_PUSH: begin
              ovalid_nxt = 1'b1;
              if (count_r == CW'(STACK_DEPTH)) begin
                ostatus_nxt = ST_FULL;
                otop_nxt    = top_r;
                odepth_nxt  = to_depth(count_r);
              end else begin
                // old top spills into the store
                wr_en       = (count_r != '0);
                top_nxt     = in_push_value;
                count_nxt   = count_r + CW'(1);
                ostatus_nxt = ST_OK;
                otop_nxt    = in_push_value;
                odepth_nxt  = to_depth(count_r + CW'(1));
              end
            end
            FN_ADD, FN_SUB, FN_MUL, FN_DIV, FN_MOD: begin
              if (count_r < CW'(OPERANDS)) begin
                ovalid_nxt  = 1'b1;
                ostatus_nxt = ST_SHORT;
                otop_nxt    = cur_top;
                odepth_nxt  = to_depth(count_r);
              end else begin
                rd_en     = 1'b1;
                state_nxt = S_OPER;
              end
            end
            default: begin
              ovalid_nxt  = 1'b1;
              ostatus_nxt = ST_OK;
              otop_nxt    = cur_top;
              odepth_nxt  = to_depth(count_r);
            end
          endcase
        end
      end
      S_OPER: begin
        if ((func_r == FN_DIV || func_r == FN_MOD) && top_r == '0) begin
          ovalid_nxt  = 1'b1;
          ostatus_nxt = ST_DIVZERO;
          otop_nxt    = top_r;
          odepth_nxt  = to_depth(count_r);
          state_nxt   = S_IDLE;
        end else begin
          alu_req.start = 1'b1;
          state_nxt     = S_WAIT;
        end
      end
      S_WAIT: begin
        if (alu_done) begin
          top_nxt     = alu_res;
          count_nxt   = count_m1;
          ovalid_nxt  = 1'b1;
          ostatus_nxt = ST_OK;
          otop_nxt    = alu_res;
          odepth_nxt  = to_depth(count_m1);
          state_nxt   = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      count_r  <= '0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      ovalid_r <= ovalid_nxt;
    end
    top_r     <= top_nxt;
    func_r    <= func_nxt;
    ostatus_r <= ostatus_nxt;
    otop_r    <= otop_nxt;
    odepth_r  <= odepth_nxt;
  end

  sau_stack_mem #(
    .STACK_DEPTH(STACK_DEPTH),
    .AW         (AW)
  ) u_mem (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(count_m1[AW-1:0]),
    .wr_data(top_r),
    .rd_en  (rd_en),
    .rd_addr(count_m2[AW-1:0]),
    .rd_data(second)
  );

  sau_alu u_alu (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (alu_req),
    .opa   (second),
    .opb   (top_r),
    .done  (alu_done),
    .result(alu_res)
  );

  assign busy          = (state_r != S_IDLE);
  assign out_valid     = ovalid_r;
  assign out_status    = ostatus_r;
  assign out_top_value = otop_r;
  assign out_depth     = odepth_r;

endmodule
`default_nettype wire
